FILE: hdl/polyphonic_tone_synth_defines.svh
// ----------------------------------------------------------------------------
// polyphonic tone synth assertion macros
// shared property wrappers for the synth rtl, clocked on the rising edge
// ----------------------------------------------------------------------------
`ifndef POLYPHONIC_TONE_SYNTH_DEFINES_SVH
`define POLYPHONIC_TONE_SYNTH_DEFINES_SVH

// property checked outside of reset
`define PTS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// property checked on every edge, reset included
`define PTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/pts_pkg.sv
// ----------------------------------------------------------------------------
// pts_pkg
// types, constants and lookup functions of the polyphonic tone synth
// ----------------------------------------------------------------------------
package pts_pkg;

  // field widths
  localparam int VOL_W      = 28;
  localparam int PHASE_W    = 32;
  localparam int SINE_W     = 16;
  localparam int FADE_W     = 16;
  localparam int KEY_W      = 16;
  localparam int KVAL_W     = 2;
  localparam int SAMPLE_W   = 32;
  localparam int IN_TDATA_W = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int PROD_W     = VOL_W + 1 + SINE_W;

  // item kinds carried in tuser
  localparam logic FUNC_KEY  = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  // key event values
  localparam logic [KVAL_W-1:0] KVAL_RELEASE = 2'd0;
  localparam logic [KVAL_W-1:0] KVAL_PRESS   = 2'd1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FADE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 1'b1;

  // register reset values
  localparam logic [FADE_W-1:0] FADE_RESET     = 16'd65503;
  localparam logic [VOL_W-1:0]  BASE_VOL_RESET = 28'd165191049;

  // angle constants for the sine table, Q30
  localparam longint unsigned PI_Q30      = 64'd3373259426;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TWO_PI_Q30  = 64'd6746518852;

  // voices with a key and a pitch
  localparam int KNOWN_VOICES = 13;

  localparam logic [PHASE_W-1:0] STEP_ROM [KNOWN_VOICES] = '{
    32'd23409862, 32'd24801879, 32'd26276681, 32'd27839173, 32'd29494578,
    32'd31248410, 32'd33106538, 32'd35075155, 32'd37160835, 32'd39370534,
    32'd41711631, 32'd44191930, 32'd46819725
  };

  localparam logic [KEY_W-1:0] KEY_ROM [KNOWN_VOICES] = '{
    16'd16, 16'd3, 16'd17, 16'd4, 16'd18, 16'd19, 16'd6, 16'd20, 16'd7,
    16'd21, 16'd8, 16'd22, 16'd23
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_KEY,
    S_TICK,
    S_DRAIN
  } state_e;

  // one voice entry as stored in the voice memory
  typedef struct packed {
    logic               held;
    logic [VOL_W-1:0]   vol;
    logic [PHASE_W-1:0] phase;
  } voice_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] voice;
  } key_hit_t;

  // voice walk into the mixer
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [PHASE_W-1:0] phase;
    logic [VOL_W-1:0]   vol;
  } mix_in_t;

  // finished mix back to the sequencer
  typedef struct packed {
    logic                vld;
    logic [SAMPLE_W-1:0] sample;
  } mix_out_t;

  // keycode to voice lookup
  function automatic key_hit_t key_lookup(input logic [KEY_W-1:0] code);
    key_hit_t r;
    r = '0;
    for (int v = 0; v < KNOWN_VOICES; v++) begin
      if (KEY_ROM[v] == code) begin
        r.hit   = 1'b1;
        r.voice = 4'(v);
      end
    end
    return r;
  endfunction

  // phase step of a voice, zero past the pitched voices
  function automatic logic [PHASE_W-1:0] step_of(input logic [4:0] v);
    logic [PHASE_W-1:0] r;
    r = '0;
    if (v < 5'(KNOWN_VOICES)) begin
      r = STEP_ROM[v[3:0]];
    end
    return r;
  endfunction

endpackage

FILE: hdl/polyphonic_tone_synth.sv
// ----------------------------------------------------------------------------
// polyphonic_tone_synth
// voice memory sequencer: key events and sample ticks over a bank of voices
// ----------------------------------------------------------------------------
//  port group   dir   beat contents
//  s_axis       in    tuser: func ; tdata: key_code[15:0], key_value[17:16]
//  m_axis       out   tdata: sample[31:0], one beat per tick
//  cfg          in    write only: 0 fade_factor, 1 base_volume
//
//  a tick walks the voice memory one voice per cycle, then passes through
//  the index, lookup, multiply, accumulate and clamp stages to the output
//  register.
//  a mapped key event reads its voice entry, then writes it back; other key events are dropped.
//  reset clears the VoiceCount entry-valid flags, so no clearing pass is needed.
//  a finished sample waits for a free output register; input then stalls.
// ----------------------------------------------------------------------------
`include "polyphonic_tone_synth_defines.svh"

module polyphonic_tone_synth #(
  parameter int VoiceCount = 13,
  parameter int SineDepth  = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // key_code [15:0], key_value [17:16], zero pad [23:18]
  input  logic [pts_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // func [0]
  input  logic [0:0]                        s_axis_tuser,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sample [31:0]
  output logic [pts_pkg::SAMPLE_W-1:0]      m_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic                              cfg_we_i,
  input  logic [pts_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pts_pkg::VOL_W-1:0]         cfg_data_i
);

  import pts_pkg::*;

  localparam int VaW = (VoiceCount > 1) ? $clog2(VoiceCount) : 1;
  localparam logic [VaW-1:0] LastVoice = VaW'(VoiceCount - 1);

  // configuration registers
  logic [FADE_W-1:0] fade_q;
  logic [VOL_W-1:0]  base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_q <= FADE_RESET;
      base_q <= BASE_VOL_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FADE: fade_q <= cfg_data_i[FADE_W-1:0];
        CFG_BASE: base_q <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // input beat decode
  logic              in_func;
  logic [KEY_W-1:0]  in_code;
  logic [KVAL_W-1:0] in_kval;
  key_hit_t          key_hit;
  logic              key_ok;

  assign in_func = s_axis_tuser[0];
  assign in_code = s_axis_tdata[KEY_W-1:0];
  assign in_kval = s_axis_tdata[KEY_W +: KVAL_W];
  assign key_hit = key_lookup(in_code);
  assign key_ok  = key_hit.hit && (6'(key_hit.voice) < 6'(VoiceCount)) &&
                   (in_kval == KVAL_PRESS || in_kval == KVAL_RELEASE);

  // sequencer
  state_e         state_q, state_d;
  logic [VaW-1:0] cnt_q, cnt_d;
  logic           rd_en;
  logic [VaW-1:0] rd_addr;
  logic           mix_ack;
  logic           out_vld_q;
  mix_out_t       mix_out;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rd_en         = 1'b0;
    rd_addr       = cnt_q;
    s_axis_tready = 1'b0;
    mix_ack       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (in_func == FUNC_TICK) begin
            state_d = S_TICK;
            cnt_d   = '0;
          end else if (key_ok) begin
            state_d = S_KEY;
            rd_en   = 1'b1;
            rd_addr = VaW'(key_hit.voice);
          end
        end
      end
      S_KEY: begin
        state_d = S_IDLE;
      end
      S_TICK: begin
        rd_en = 1'b1;
        if (cnt_q == LastVoice) begin
          state_d = S_DRAIN;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: begin
        if (mix_out.vld && (!out_vld_q || m_axis_tready)) begin
          mix_ack = 1'b1;
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // read-side tracking, registered in step with the memory read data
  logic           s1_vld_q, s1_last_q;
  logic [VaW-1:0] s1_addr_q;
  logic           key_press_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s1_last_q <= 1'b0;
    end else begin
      s1_vld_q  <= (state_q == S_TICK);
      s1_last_q <= (state_q == S_TICK) && (cnt_q == LastVoice);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_addr_q   <= rd_addr;
      key_press_q <= (in_kval == KVAL_PRESS);
    end
  end

  // voice memory
  logic [$bits(voice_t)-1:0] ram_rdata;
  voice_t                    wr_data;
  logic                      wr_en;

  pts_ram #(
    .Width ($bits(voice_t)),
    .Depth (VoiceCount)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // entry-valid flags, an entry never written reads as zero
  logic [VoiceCount-1:0] valid_q;
  voice_t                entry;

  assign entry = valid_q[s1_addr_q] ? voice_t'(ram_rdata) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[s1_addr_q] <= 1'b1;
    end
  end

  // modify and write back: key update or phase advance with release fade
  logic [VOL_W+FADE_W-1:0] fade_prod;

  assign fade_prod = (VOL_W + FADE_W)'(entry.vol) * (VOL_W + FADE_W)'(fade_q);

  always_comb begin
    wr_en   = 1'b0;
    wr_data = entry;
    if (state_q == S_KEY) begin
      wr_en        = 1'b1;
      wr_data.held = key_press_q;
      if (key_press_q) begin
        wr_data.vol = base_q;
      end
    end else if (s1_vld_q) begin
      wr_en         = 1'b1;
      wr_data.phase = entry.phase + step_of(5'(s1_addr_q));
      if (!entry.held && (entry.vol != '0)) begin
        wr_data.vol = fade_prod[FADE_W +: VOL_W];
      end
    end
  end

  // mix pipeline
  mix_in_t mix_in;

  assign mix_in.vld   = s1_vld_q;
  assign mix_in.last  = s1_last_q;
  assign mix_in.phase = entry.phase;
  assign mix_in.vol   = entry.vol;

  pts_mixer #(
    .VoiceCount (VoiceCount),
    .SineDepth  (SineDepth)
  ) u_mixer (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .mix_in_i  (mix_in),
    .ack_i     (mix_ack),
    .mix_out_o (mix_out)
  );

  // output register
  logic [SAMPLE_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (mix_ack) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mix_ack) begin
      out_data_q <= mix_out.sample;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // checks
  `PTS_ASSERT(a_no_wr_clash, clk_i, rst_ni, !(state_q == S_KEY && s1_vld_q), "key and tick write back overlap")
  `PTS_ASSERT(a_busy_in_tick, clk_i, rst_ni, s1_vld_q |-> !s_axis_tready, "input taken during voice walk")
  `PTS_ASSERT(a_ack_has_res, clk_i, rst_ni, mix_ack |-> mix_out.vld, "mix taken with no result")
  `PTS_ASSERT(a_ack_loads_out, clk_i, rst_ni, mix_ack |=> m_axis_tvalid, "taken mix not shown on output")
  `PTS_ASSERT_ALWAYS(a_reset_idle, clk_i, !rst_ni |=> (state_q == S_IDLE && !m_axis_tvalid), "not idle in reset")

endmodule

FILE: hdl/pts_ram.sv
// ----------------------------------------------------------------------------
// pts_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module pts_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/pts_sine_rom.sv
// ----------------------------------------------------------------------------
// pts_sine_rom
// q1.15 sine table built at elaboration, registered read
// ----------------------------------------------------------------------------
module pts_sine_rom #(
  parameter int Depth = 1024
) (
  input  logic                              clk_i,
  input  logic [$clog2(Depth)-1:0]          addr_i,
  output logic signed [pts_pkg::SINE_W-1:0] data_o
);

  import pts_pkg::*;

  // folded angle, taylor series up to x^11, rounded to q1.15
  function automatic logic signed [SINE_W-1:0] sine_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned mag;
    longint          sum;
    logic            neg;
    logic signed [SINE_W-1:0] r;
    x   = (k * TWO_PI_Q30) / Depth;
    neg = 1'b0;
    if (x >= PI_Q30) begin
      x   = x - PI_Q30;
      neg = 1'b1;
    end
    if (x > HALF_PI_Q30) begin
      x = PI_Q30 - x;
    end
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;
    sum  = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;
    sum  = sum + longint'(term);
    term = ((term * x2) >> 30) / 110;
    sum  = sum - longint'(term);
    if (sum < 0) begin
      sum = 0;
    end
    mag = ((unsigned'(sum) * 64'd32767) + 64'd536870912) >> 30;
    if (mag > 64'd32767) begin
      mag = 64'd32767;
    end
    r = neg ? -SINE_W'(mag) : SINE_W'(mag);
    return r;
  endfunction

  logic signed [SINE_W-1:0] rom_w [Depth];
  logic signed [SINE_W-1:0] data_q;

  // table contents
  for (genvar k = 0; k < Depth; k++) begin : g_entry
    localparam logic signed [SINE_W-1:0] EntryVal = sine_entry(64'(k));
    assign rom_w[k] = EntryVal;
  end

  // registered lookup
  always_ff @(posedge clk_i) begin
    data_q <= rom_w[addr_i];
  end

  assign data_o = data_q;

endmodule

FILE: hdl/pts_mixer.sv
// ----------------------------------------------------------------------------
// pts_mixer
// per-voice sine lookup, volume scaling, accumulation and saturation
// ----------------------------------------------------------------------------
module pts_mixer #(
  parameter int VoiceCount = 13,
  parameter int SineDepth  = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pts_pkg::mix_in_t   mix_in_i,
  input  logic               ack_i,
  output pts_pkg::mix_out_t  mix_out_o
);

  import pts_pkg::*;

  localparam int IdxW  = $clog2(SineDepth);
  localparam int IprW  = PHASE_W + IdxW + 1;
  localparam int AccW  = PROD_W + 2 + $clog2(VoiceCount + 1);
  localparam int QW    = AccW - 15;
  localparam logic signed [QW-1:0] QMax = QW'(32'sh7fffffff);
  localparam logic signed [QW-1:0] QMin = QW'(32'sh80000000);
  localparam logic [AccW-1:0] RoundBias = AccW'(32767);

  // stage a: table index
  logic [IprW-1:0]   idx_prod;
  logic              a_vld_q, a_last_q;
  logic [IdxW-1:0]   a_idx_q;
  logic [VOL_W-1:0]  a_vol_q;

  assign idx_prod = IprW'(mix_in_i.phase) * IprW'(SineDepth);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q  <= 1'b0;
      a_last_q <= 1'b0;
    end else begin
      a_vld_q  <= mix_in_i.vld;
      a_last_q <= mix_in_i.vld && mix_in_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q <= idx_prod[PHASE_W +: IdxW];
    a_vol_q <= mix_in_i.vol;
  end

  // stage b: sine lookup
  logic                     b_vld_q, b_last_q;
  logic [VOL_W-1:0]         b_vol_q;
  logic signed [SINE_W-1:0] sine_w;

  pts_sine_rom #(
    .Depth (SineDepth)
  ) u_sine_rom (
    .clk_i  (clk_i),
    .addr_i (a_idx_q),
    .data_o (sine_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q  <= 1'b0;
      b_last_q <= 1'b0;
    end else begin
      b_vld_q  <= a_vld_q;
      b_last_q <= a_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b_vol_q <= a_vol_q;
  end

  // stage c: volume times sine
  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] c_prod_q;
  logic                     c_vld_q, c_last_q;

  assign prod_w = $signed({1'b0, b_vol_q}) * sine_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q  <= 1'b0;
      c_last_q <= 1'b0;
    end else begin
      c_vld_q  <= b_vld_q;
      c_last_q <= b_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    c_prod_q <= prod_w;
  end

  // accumulate over the voices
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   fin_q;

  always_comb begin
    acc_d = acc_q;
    if (ack_i) begin
      acc_d = '0;
    end else if (c_vld_q) begin
      acc_d = acc_q + AccW'(c_prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      fin_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      fin_q <= c_vld_q && c_last_q;
    end
  end

  // divide by 2^15 toward zero, then clamp to 32 bits
  logic [AccW-1:0]         acc_adj;
  logic signed [QW-1:0]    quo;
  logic [SAMPLE_W-1:0]     sat;

  always_comb begin
    acc_adj = acc_q + (acc_q[AccW-1] ? RoundBias : '0);
    quo     = acc_adj[AccW-1:15];
    if (quo > QMax) begin
      sat = 32'h7fffffff;
    end else if (quo < QMin) begin
      sat = 32'h80000000;
    end else begin
      sat = quo[SAMPLE_W-1:0];
    end
  end

  // result held until the sequencer takes it
  logic                res_vld_q;
  logic [SAMPLE_W-1:0] res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (fin_q) begin
      res_vld_q <= 1'b1;
    end else if (ack_i) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      res_q <= sat;
    end
  end

  assign mix_out_o.vld    = res_vld_q;
  assign mix_out_o.sample = res_q;

endmodule
